FILE: design/vra_pkg.sv
// Shared types, constants and codes for the virtual region allocator.
`timescale 1ns / 1ps
`default_nettype none

package vra_pkg;

   localparam int PAGE_BYTES  = 4096;
   localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
   localparam int MAX_REGIONS = 512;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int ADDR_W      = 32;
   localparam int PAGE_W      = 21;
   localparam int FUNC_W      = 2;
   localparam int STATUS_W    = 2;

   localparam logic [FUNC_W-1:0] FUNC_ALLOCATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CHECK    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 2'd3;

   localparam logic CSR_POOL_BASE  = 1'b0;
   localparam logic CSR_POOL_BYTES = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [PAGE_W-1:0] pages;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_idx;
      entry_type         wr_entry;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_idx;
   } table_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   region_address;
      logic [PAGE_W-1:0]   page_count;
      logic                in_pool;
   } result_type;

endpackage

`default_nettype wire

FILE: design/virtual_region_allocator.sv
// Top level of the virtual region allocator: CSRs, engine, table and result register.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_func, req_size, req_address
// rsp_      out        rsp_valid / rsp_ready  rsp_status, rsp_region_address,
//                                             rsp_page_count, rsp_in_pool
// csr_      in         csr_write_enable       csr_index, csr_write_data
//
// Check and unused function codes pass from transfer through DECODE to FINISH; allocate
// adds an ALLOC_RD state when it reads the last table entry for its base address.
// Release scans all N regions through the single table read port, then moves the
// entries above the hit down one slot each. Reset is synchronous and clears the
// sequencer and region count; used pages reset to one, the table page. The table
// itself is not cleared, since only entries below the region count are read.
// A finished result waits in the output register; the engine takes the next request
// while it waits, and only holds its own result until the register is free.

module virtual_region_allocator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [vra_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [vra_pkg::ADDR_W-1:0]    req_size,
   input  wire logic [vra_pkg::ADDR_W-1:0]    req_address,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [vra_pkg::STATUS_W-1:0]       rsp_status,
   output logic [vra_pkg::ADDR_W-1:0]         rsp_region_address,
   output logic [vra_pkg::PAGE_W-1:0]         rsp_page_count,
   output logic                               rsp_in_pool,
   input  wire logic                          csr_write_enable,
   input  wire logic                          csr_index,
   input  wire logic [vra_pkg::ADDR_W-1:0]    csr_write_data
);

   logic [vra_pkg::ADDR_W-1:0] pool_base_ff;
   logic [vra_pkg::ADDR_W-1:0] pool_bytes_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   vra_pkg::result_type        rsp_data_ff, rsp_data_in;

   logic                       slot_free;
   logic                       done;
   vra_pkg::result_type        result;
   vra_pkg::table_req_type     table_req;
   vra_pkg::entry_type         rd_entry;

   // Users write configuration registers only while the block is idle (not enforced).
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= '0;
         pool_bytes_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            vra_pkg::CSR_POOL_BASE:  pool_base_ff  <= csr_write_data;
            vra_pkg::CSR_POOL_BYTES: pool_bytes_ff <= csr_write_data;
            default:                 pool_base_ff  <= pool_base_ff;
         endcase
      end
   end

   vra_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_size    (req_size),
      .req_address (req_address),
      .pool_base   (pool_base_ff),
      .pool_bytes  (pool_bytes_ff),
      .slot_free   (slot_free),
      .done        (done),
      .result      (result),
      .table_req   (table_req),
      .rd_entry    (rd_entry)
   );

   vra_region_table u_table (
      .clock     (clock),
      .table_req (table_req),
      .rd_entry  (rd_entry)
   );

   // The output register is free when empty or when its result transfers now.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_data_ff.status;
   assign rsp_region_address = rsp_data_ff.region_address;
   assign rsp_page_count     = rsp_data_ff.page_count;
   assign rsp_in_pool        = rsp_data_ff.in_pool;

endmodule

`default_nettype wire

FILE: design/vra_region_table.sv
// Region table memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module vra_region_table (
   input  wire logic                  clock,
   input  wire vra_pkg::table_req_type table_req,
   output vra_pkg::entry_type          rd_entry
);

   vra_pkg::entry_type mem [vra_pkg::MAX_REGIONS];
   vra_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (table_req.wr_en) begin
         mem[table_req.wr_idx] <= table_req.wr_entry;
      end
      if (table_req.rd_en) begin
         rd_entry_ff <= mem[table_req.rd_idx];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

FILE: design/vra_engine.sv
// Sequencer that runs allocate, release and check over the region table.
`timescale 1ns / 1ps
`default_nettype none

module vra_engine (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [vra_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [vra_pkg::ADDR_W-1:0]     req_size,
   input  wire logic [vra_pkg::ADDR_W-1:0]     req_address,
   input  wire logic [vra_pkg::ADDR_W-1:0]     pool_base,
   input  wire logic [vra_pkg::ADDR_W-1:0]     pool_bytes,
   input  wire logic                           slot_free,
   output logic                                done,
   output vra_pkg::result_type                 result,
   output vra_pkg::table_req_type              table_req,
   input  wire vra_pkg::entry_type             rd_entry
);

   typedef enum logic [2:0] {
      IDLE, DECODE, ALLOC_RD, SEARCH, HIT_RD, SHIFT, CLOSE, FINISH
   } state_type;

   state_type                       state_ff, state_in;
   logic [vra_pkg::FUNC_W-1:0]      func_ff, func_in;
   logic [vra_pkg::ADDR_W-1:0]      size_ff, size_in;
   logic [vra_pkg::ADDR_W-1:0]      addr_ff, addr_in;
   logic [vra_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [vra_pkg::PAGE_W-1:0]      used_ff, used_in;
   logic [vra_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic [vra_pkg::IDX_W-1:0]       hit_ff, hit_in;
   logic                            found_ff, found_in;
   logic [vra_pkg::PAGE_W-1:0]      need_ff, need_in;
   vra_pkg::result_type             res_ff, res_in;

   logic [vra_pkg::PAGE_W-1:0]      need_calc;
   logic [vra_pkg::PAGE_W-1:0]      total_pages;
   logic [vra_pkg::PAGE_W-1:0]      avail_pages;
   logic [vra_pkg::ADDR_W:0]        pool_end;
   logic [vra_pkg::ADDR_W-1:0]      next_base;
   logic [vra_pkg::CNT_W-1:0]       idx_next;
   logic [vra_pkg::CNT_W-1:0]       hit_next;
   logic                            match;
   logic                            found_now;
   logic [vra_pkg::IDX_W-1:0]       hit_now;

   // Page rounding from the latched request size; free space and pool bound from the CSRs.
   assign need_calc   = vra_pkg::PAGE_W'(size_ff >> vra_pkg::PAGE_SHIFT)
                      + vra_pkg::PAGE_W'(|size_ff[vra_pkg::PAGE_SHIFT-1:0]);
   assign total_pages = vra_pkg::PAGE_W'(pool_bytes >> vra_pkg::PAGE_SHIFT);
   assign avail_pages = (total_pages > used_ff) ? total_pages - used_ff : '0;
   assign pool_end    = {1'b0, pool_base} + {1'b0, pool_bytes};
   assign next_base   = rd_entry.base
                      + (vra_pkg::ADDR_W'(rd_entry.pages) << vra_pkg::PAGE_SHIFT);
   assign idx_next    = idx_ff + 1'b1;
   assign hit_next    = {1'b0, hit_ff} + 1'b1;
   assign match       = (rd_entry.base == addr_ff);
   assign found_now   = found_ff | match;
   assign hit_now     = match ? idx_ff[vra_pkg::IDX_W-1:0] : hit_ff;

   assign req_ready = (state_ff == IDLE);
   assign done      = (state_ff == FINISH) && slot_free;
   assign result    = res_ff;

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      size_in   = size_ff;
      addr_in   = addr_ff;
      count_in  = count_ff;
      used_in   = used_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      found_in  = found_ff;
      need_in   = need_ff;
      res_in    = res_ff;
      table_req = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               size_in  = req_size;
               addr_in  = req_address;
               state_in = DECODE;
            end
         end
         DECODE: begin
            res_in   = '0;
            state_in = FINISH;
            case (func_ff)
               vra_pkg::FUNC_ALLOCATE: begin
                  need_in = need_calc;
                  if (need_calc > avail_pages) begin
                     res_in.status = vra_pkg::STATUS_NO_SPACE;
                  end else if (count_ff >= vra_pkg::CNT_W'(vra_pkg::MAX_REGIONS - 1)) begin
                     res_in.status = vra_pkg::STATUS_TABLE_FULL;
                  end else if (count_ff == '0) begin
                     // The first region sits just above the table page.
                     table_req.wr_en          = 1'b1;
                     table_req.wr_idx         = '0;
                     table_req.wr_entry.base  = pool_base
                                              + vra_pkg::ADDR_W'(vra_pkg::PAGE_BYTES);
                     table_req.wr_entry.pages = need_calc;
                     count_in                 = count_ff + 1'b1;
                     used_in                  = used_ff + need_calc;
                     res_in.region_address    = table_req.wr_entry.base;
                     res_in.page_count        = need_calc;
                  end else begin
                     table_req.rd_en  = 1'b1;
                     table_req.rd_idx = vra_pkg::IDX_W'(count_ff - 1'b1);
                     state_in         = ALLOC_RD;
                  end
               end
               vra_pkg::FUNC_RELEASE: begin
                  found_in = 1'b0;
                  hit_in   = '0;
                  if (count_ff == '0) begin
                     res_in.status = vra_pkg::STATUS_NOT_FOUND;
                  end else begin
                     table_req.rd_en  = 1'b1;
                     table_req.rd_idx = '0;
                     idx_in           = '0;
                     state_in         = SEARCH;
                  end
               end
               vra_pkg::FUNC_CHECK: begin
                  res_in.in_pool = (addr_ff >= pool_base)
                                && ({1'b0, addr_ff} < pool_end);
               end
               default: begin
                  res_in = '0;
               end
            endcase
         end
         ALLOC_RD: begin
            // Place the new region right after the last one.
            table_req.wr_en          = 1'b1;
            table_req.wr_idx         = count_ff[vra_pkg::IDX_W-1:0];
            table_req.wr_entry.base  = next_base;
            table_req.wr_entry.pages = need_ff;
            count_in                 = count_ff + 1'b1;
            used_in                  = used_ff + need_ff;
            res_in.region_address    = next_base;
            res_in.page_count        = need_ff;
            state_in                 = FINISH;
         end
         SEARCH: begin
            // The last matching entry wins, so the scan always covers every stored region.
            found_in = found_now;
            hit_in   = hit_now;
            if (idx_next < count_ff) begin
               table_req.rd_en  = 1'b1;
               table_req.rd_idx = idx_next[vra_pkg::IDX_W-1:0];
               idx_in           = idx_next;
            end else if (!found_now) begin
               res_in.status = vra_pkg::STATUS_NOT_FOUND;
               state_in      = FINISH;
            end else begin
               table_req.rd_en  = 1'b1;
               table_req.rd_idx = hit_now;
               state_in         = HIT_RD;
            end
         end
         HIT_RD: begin
            need_in               = rd_entry.pages;
            res_in.region_address = rd_entry.base;
            res_in.page_count     = rd_entry.pages;
            if (hit_next < count_ff) begin
               table_req.rd_en  = 1'b1;
               table_req.rd_idx = hit_next[vra_pkg::IDX_W-1:0];
               idx_in           = hit_next;
               state_in         = SHIFT;
            end else begin
               state_in = CLOSE;
            end
         end
         SHIFT: begin
            // Each later entry moves down one slot as it is read back.
            table_req.wr_en    = 1'b1;
            table_req.wr_idx   = vra_pkg::IDX_W'(idx_ff - 1'b1);
            table_req.wr_entry = rd_entry;
            if (idx_next < count_ff) begin
               table_req.rd_en  = 1'b1;
               table_req.rd_idx = idx_next[vra_pkg::IDX_W-1:0];
               idx_in           = idx_next;
            end else begin
               state_in = CLOSE;
            end
         end
         CLOSE: begin
            count_in = count_ff - 1'b1;
            used_in  = (used_ff > need_ff) ? used_ff - need_ff : '0;
            state_in = FINISH;
         end
         FINISH: begin
            if (slot_free) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         used_ff  <= vra_pkg::PAGE_W'(1);
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         used_ff  <= used_in;
         found_ff <= found_in;
      end
      func_ff <= func_in;
      size_ff <= size_in;
      addr_ff <= addr_in;
      idx_ff  <= idx_in;
      hit_ff  <= hit_in;
      need_ff <= need_in;
      res_ff  <= res_in;
   end

   // The region count never exceeds MAX_REGIONS - 1, so at most 511 user regions.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= vra_pkg::CNT_W'(vra_pkg::MAX_REGIONS - 1))
      else $error("region count beyond table capacity");

   // The table page is always accounted for.
   assert property (@(posedge clock) disable iff (reset) used_ff != '0)
      else $error("used page count lost the table page");

   // Writes never land beyond the first free slot.
   assert property (@(posedge clock) disable iff (reset)
      table_req.wr_en |-> ({1'b0, table_req.wr_idx} <= count_ff))
      else $error("table write beyond region count");

   // An accepted request is decoded in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == DECODE)
      else $error("accepted request was not decoded");

endmodule

`default_nettype wire
